@@ src/assert_macros.svh @@
// Assertion helpers used by the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ssort_pkg.sv @@
package ssort_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Ordering modes held in the configuration register.
  localparam logic [1:0] MODE_ASC   = 2'd0;
  localparam logic [1:0] MODE_DESC  = 2'd1;
  localparam logic [1:0] MODE_SPLIT = 2'd2;
  localparam logic [1:0] MODE_ASIS  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LOADI,
    ST_CMP,
    ST_WB,
    ST_EMIT
  } state_t;

  // True when a, held at the lower position, must trade places with b.
  function automatic logic needs_swap(input data_t a, input data_t b, input logic [1:0] mode);
    logic a_pos;
    logic b_pos;
    logic res;
    a_pos = (a > 0);
    b_pos = (b > 0);
    res   = 1'b0;
    unique case (mode)
      MODE_ASC:  res = (a > b);
      MODE_DESC: res = (a < b);
      MODE_SPLIT: begin
        if (a_pos && b_pos) begin
          res = (a < b);
        end else if (a_pos != b_pos) begin
          res = b_pos;
        end else begin
          res = (a > b);
        end
      end
      MODE_ASIS: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

@@ src/ssort_ram.sv @@
module ssort_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/sign_split_sorter.sv @@
// The block collects signed 32-bit items, one per clock, while busy is low; an
// item is taken at each rising edge with start high and busy low. An item with
// in_last set closes the set: busy rises, the stored elements are reordered in
// place in a 64-entry memory by a compare-exchange sort (skipped in the
// keep-order mode), and then the whole run leaves on the out_ ports, one
// element per cycle, each for exactly one cycle marked by out_valid. The
// receiver cannot stall the run, so it must take every strobed item. Items that
// arrive with the store full are dropped, and out_overflowed is set on every
// item of that run. For a sorted run of n elements the sort makes one
// comparison per cycle within a pass, through the single read port of the
// memory, n(n-1)/2 comparisons in all; a head state starts the first read,
// each of the n-1 outer passes adds a load state and a write-back state, and
// the emit state reads the run out. In the keep-order mode, and for a run of
// one element, the run goes straight to read-out. Each element is strobed in
// the cycle after it is read; a run's final item comes as busy goes low.
// Loading takes one item per cycle. The mode is read both at the edge that
// takes the closing item and at every comparison of the sort, so the
// configuration register should only be written while busy is low and not at
// the edge that takes a closing item.
`include "assert_macros.svh"

module sign_split_sorter (
  input  logic                     clk,
  input  logic                     rst_n,
  // Item input.
  input  logic                     start,
  output logic                     busy,
  input  logic signed [31:0]       in_value,
  input  logic                     in_last,
  // Result output.
  output logic                     out_valid,
  output logic signed [31:0]       out_value_res,
  output logic                     out_last_res,
  output logic                     out_overflowed,
  // Configuration write.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_order_mode
);

  ssort_pkg::state_t state_r, state_nxt;
  ssort_pkg::cnt_t   cnt_r, cnt_nxt;
  ssort_pkg::addr_t  i_r, i_nxt;
  ssort_pkg::addr_t  j_r, j_nxt;
  ssort_pkg::data_t  cur_r, cur_nxt;
  logic              dropped_r, dropped_nxt;
  logic [1:0]        mode_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              ram_we, ram_re;
  ssort_pkg::addr_t  ram_waddr, ram_raddr;
  ssort_pkg::data_t  ram_wdata;
  logic [31:0]       ram_rdata;
  ssort_pkg::data_t  rd_val;

  logic              accept;
  logic              full;
  ssort_pkg::cnt_t   load_n;
  logic              j_more;
  logic              i_more;
  logic              emit_done;

  assign busy      = (state_r != ssort_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign rd_val    = ssort_pkg::data_t'(ram_rdata);

  assign full      = (cnt_r == ssort_pkg::cnt_t'(ssort_pkg::CAPACITY));
  assign load_n    = full ? cnt_r : cnt_r + ssort_pkg::cnt_t'(1);
  // Loop bounds of the sort and of the read-out, compared against the count.
  assign j_more    = (ssort_pkg::cnt_t'(j_r) + ssort_pkg::cnt_t'(1)) < cnt_r;
  assign i_more    = (ssort_pkg::cnt_t'(i_r) + ssort_pkg::cnt_t'(2)) < cnt_r;
  assign emit_done = (ssort_pkg::cnt_t'(i_r) + ssort_pkg::cnt_t'(1)) == cnt_r;

  ssort_ram #(
    .Width (ssort_pkg::DATA_W),
    .Depth (ssort_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssort_pkg::ST_IDLE: begin
        if (accept && in_last) begin
          if ((mode_r != ssort_pkg::MODE_ASIS) && (load_n > ssort_pkg::cnt_t'(1))) begin
            state_nxt = ssort_pkg::ST_HEAD;
          end else begin
            state_nxt = ssort_pkg::ST_EMIT;
          end
        end
      end
      ssort_pkg::ST_HEAD:  state_nxt = ssort_pkg::ST_LOADI;
      ssort_pkg::ST_LOADI: state_nxt = ssort_pkg::ST_CMP;
      ssort_pkg::ST_CMP: begin
        if (!j_more) begin
          state_nxt = ssort_pkg::ST_WB;
        end
      end
      ssort_pkg::ST_WB: begin
        state_nxt = i_more ? ssort_pkg::ST_LOADI : ssort_pkg::ST_EMIT;
      end
      ssort_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ssort_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssort_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control. During the sort, cur_r holds the element
  // destined for position i; each returned element j is compared with it,
  // and if needs_swap holds the two are exchanged by writing cur_r back at j.
  // Reads always run one address ahead of the write, so the ports never touch the same entry.
  always_comb begin
    cnt_nxt       = cnt_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r;
    ram_wdata     = cur_r;
    ram_re        = 1'b0;
    ram_raddr     = i_r;
    unique case (state_r)
      ssort_pkg::ST_IDLE: begin
        if (accept) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[ssort_pkg::ADDR_W-1:0];
            ram_wdata = in_value;
            cnt_nxt   = load_n;
          end
          if (in_last) begin
            i_nxt = '0;
          end
        end
      end
      ssort_pkg::ST_HEAD: begin
        ram_re = 1'b1;
      end
      ssort_pkg::ST_LOADI: begin
        cur_nxt   = rd_val;
        ram_re    = 1'b1;
        ram_raddr = i_r + ssort_pkg::addr_t'(1);
        j_nxt     = i_r + ssort_pkg::addr_t'(1);
      end
      ssort_pkg::ST_CMP: begin
        if (ssort_pkg::needs_swap(cur_r, rd_val, mode_r)) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = cur_r;
          cur_nxt   = rd_val;
        end
        if (j_more) begin
          ram_re    = 1'b1;
          ram_raddr = j_r + ssort_pkg::addr_t'(1);
          j_nxt     = j_r + ssort_pkg::addr_t'(1);
        end
      end
      ssort_pkg::ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = cur_r;
        if (i_more) begin
          ram_re    = 1'b1;
          ram_raddr = i_r + ssort_pkg::addr_t'(1);
          i_nxt     = i_r + ssort_pkg::addr_t'(1);
        end else begin
          i_nxt = '0;
        end
      end
      ssort_pkg::ST_EMIT: begin
        ram_re        = 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = emit_done;
        out_ovf_nxt   = dropped_r;
        i_nxt         = i_r + ssort_pkg::addr_t'(1);
        if (emit_done) begin
          cnt_nxt     = '0;
          dropped_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssort_pkg::ST_IDLE;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      mode_r      <= ssort_pkg::MODE_ASC;
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_order_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // The memory read register is only loaded on reads, so it holds the item
  // steady during its strobe cycle even if a new load begins.
  assign out_valid      = out_valid_r;
  assign out_value_res  = rd_val;
  assign out_last_res   = out_last_r;
  assign out_overflowed = out_ovf_r;

  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= ssort_pkg::cnt_t'(ssort_pkg::CAPACITY), "element count above capacity")
  `ASSERT_IMPL(a_no_port_clash, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit the same entry")
  `ASSERT_NEXT(a_last_goes_busy, clk, rst_n, start && !busy && in_last, busy, "closing item did not start a run")
  `ASSERT_IMPL(a_run_cleared, clk, rst_n, out_valid_r && out_last_r, !busy && cnt_r == '0 && !dropped_r, "run state not cleared at final item")
  `ASSERT_NEXT(a_run_ends, clk, rst_n, out_valid_r && out_last_r, !out_valid_r, "output continued past final item")

endmodule
